@@ sv/matrix_vector_multiply_top_assert.svh @@
// Assertion macros for the checker file of the matrix-vector engine.
`ifndef MATRIX_VECTOR_MULTIPLY_TOP_ASSERT_SVH
`define MATRIX_VECTOR_MULTIPLY_TOP_ASSERT_SVH

// Same-cycle implication, off while reset is held.
`define MVM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, off while reset is held.
`define MVM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication that also runs during reset.
`define MVM_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

@@ sv/mvm_pkg.sv @@
`default_nettype none
package mvm_pkg;

    localparam int IDX_W    = 4;                 // row and column index width
    localparam int IDX_LIM  = 1 << IDX_W;        // most rows or columns an index can reach
    localparam int DATA_W   = 32;                // Q16.16 word
    localparam int PROD_W   = 2 * DATA_W;        // Q32.32 product
    localparam int ACC_W    = PROD_W + IDX_W + 1; // exact sum of up to IDX_LIM products
    localparam int TDATA_W  = 40;
    localparam int CFG_W    = 5;
    localparam int QUEUE_DEPTH = 4;
    localparam int QP_W     = 2;

    localparam logic [ACC_W-1:0] RND_BIAS = {{(ACC_W-16){1'b0}}, 16'h8000};

    localparam logic [1:0] ACT_LOAD_MAT = 2'd0;
    localparam logic [1:0] ACT_LOAD_VEC = 2'd1;
    localparam logic [1:0] ACT_COMPUTE  = 2'd2;

    localparam logic [1:0] KIND_MAT = 2'd0;
    localparam logic [1:0] KIND_VEC = 2'd1;
    localparam logic [1:0] KIND_CMP = 2'd2;

    localparam logic CFG_ROWS_USED = 1'b0;
    localparam logic CFG_COLS_USED = 1'b1;

    typedef struct packed {
        logic [1:0]        kind;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [DATA_W-1:0] data;
    } q_entry_t;

    typedef struct packed {
        logic [IDX_W-1:0] rows_last;
        logic [IDX_W-1:0] cols_last;
    } cfg_t;

    typedef struct packed {
        logic             first;
        logic             last_col;
        logic             last_row;
        logic [IDX_W-1:0] row;
    } tag_t;

endpackage
`default_nettype wire

@@ sv/matrix_vector_multiply_top.sv @@
// Channel   Dir  tdata (low bit up)                          tuser / tlast
// s_        in   row_index[3:0] col_index[7:4] element[39:8]  tuser[1:0] action
// m_        out  out_row[3:0] dot_value[35:4] zero[39:36]     tlast last
// cfg_      in   cfg_index selects rows_used or cols_used, cfg_wdata value
//
// A load leaves the queue and writes the matrix or vector storage; a compute leaves the queue,
// then makes rows_used * cols_used matrix and vector reads through the single multiplier, and
// the products drain through the multiply, accumulate and round stages. Reset clears the
// control state; storage is not cleared.
// A result held in the output register and not taken stalls the back end; the front keeps
// accepting transactions until its four-entry queue is full.
`default_nettype none
module matrix_vector_multiply_top #(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 16
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // row_index, col_index, element
    input  wire logic [mvm_pkg::TDATA_W-1:0]  s_tdata,
    // action
    input  wire logic [1:0]                   s_tuser,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // out_row, dot_value, zero fill
    output logic [mvm_pkg::TDATA_W-1:0]       m_tdata,
    output logic                              m_tlast,
    input  wire logic                         cfg_we,
    input  wire logic                         cfg_index,
    input  wire logic [mvm_pkg::CFG_W-1:0]    cfg_wdata
);
    import mvm_pkg::*;

    logic              q_full;
    logic              q_empty;
    logic              q_push;
    logic              q_pop;
    q_entry_t          q_in;
    q_entry_t          q_out;
    cfg_t              cfg;
    logic [IDX_W-1:0]  out_row;
    logic [DATA_W-1:0] dot_value;

    mvm_front #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_in),
        .cfg       (cfg)
    );

    mvm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    mvm_back #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_data  (q_out),
        .q_pop   (q_pop),
        .cfg     (cfg),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_row   (out_row),
        .m_dot   (dot_value),
        .m_last  (m_tlast)
    );

    assign m_tdata = {{(TDATA_W-IDX_W-DATA_W){1'b0}}, dot_value, out_row};

endmodule
`default_nettype wire

@@ sv/mvm_queue.sv @@
`default_nettype none
module mvm_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire mvm_pkg::q_entry_t push_data,
    output logic                   full,
    input  wire logic              pop,
    output mvm_pkg::q_entry_t      pop_data,
    output logic                   empty
);
    import mvm_pkg::*;

    q_entry_t         slot_reg [QUEUE_DEPTH];
    logic [QP_W-1:0]  wr_ptr_reg;
    logic [QP_W-1:0]  rd_ptr_reg;
    logic [QP_W:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == (QP_W+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)      count_reg <= count_reg + 1'b1;
            else if (!do_push && do_pop) count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule
`default_nettype wire

@@ sv/mvm_front.sv @@
`default_nettype none
module mvm_front #(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [mvm_pkg::TDATA_W-1:0]   s_tdata,
    input  wire logic [1:0]                    s_tuser,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_index,
    input  wire logic [mvm_pkg::CFG_W-1:0]     cfg_wdata,
    input  wire logic                          q_full,
    output logic                               q_push,
    output mvm_pkg::q_entry_t                  q_data,
    output mvm_pkg::cfg_t                      cfg
);
    import mvm_pkg::*;

    localparam int ROW_LIM = (MAX_ROWS < IDX_LIM) ? MAX_ROWS : IDX_LIM;
    localparam int COL_LIM = (MAX_COLS < IDX_LIM) ? MAX_COLS : IDX_LIM;

    logic [CFG_W-1:0] rows_used_reg;
    logic [CFG_W-1:0] cols_used_reg;
    logic [CFG_W-1:0] rows_eff;
    logic [CFG_W-1:0] cols_eff;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             keep;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_used_reg <= CFG_W'(IDX_LIM);
            cols_used_reg <= CFG_W'(IDX_LIM);
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_ROWS_USED: rows_used_reg <= cfg_wdata;
                CFG_COLS_USED: cols_used_reg <= cfg_wdata;
                default:       rows_used_reg <= rows_used_reg;
            endcase
        end
    end

    // Zero counts as one; clip at what the storage holds.
    always_comb begin
        rows_eff = (rows_used_reg == '0) ? CFG_W'(1) : rows_used_reg;
        if (int'(rows_eff) > ROW_LIM) rows_eff = CFG_W'(ROW_LIM);
        cols_eff = (cols_used_reg == '0) ? CFG_W'(1) : cols_used_reg;
        if (int'(cols_eff) > COL_LIM) cols_eff = CFG_W'(COL_LIM);
    end

    assign cfg.rows_last = IDX_W'(rows_eff - CFG_W'(1));
    assign cfg.cols_last = IDX_W'(cols_eff - CFG_W'(1));

    assign row = s_tdata[IDX_W-1:0];
    assign col = s_tdata[2*IDX_W-1:IDX_W];

    // Classify the transaction; drop unused actions and out-of-range loads.
    always_comb begin
        keep        = 1'b0;
        q_data.kind = KIND_CMP;
        case (s_tuser)
            ACT_LOAD_MAT: begin
                keep        = (int'(row) < ROW_LIM) && (int'(col) < COL_LIM);
                q_data.kind = KIND_MAT;
            end
            ACT_LOAD_VEC: begin
                keep        = (int'(col) < COL_LIM);
                q_data.kind = KIND_VEC;
            end
            ACT_COMPUTE: begin
                keep        = 1'b1;
                q_data.kind = KIND_CMP;
            end
            default: keep = 1'b0;
        endcase
    end

    assign q_data.row  = row;
    assign q_data.col  = col;
    assign q_data.data = s_tdata[2*IDX_W+DATA_W-1:2*IDX_W];

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready && keep;

endmodule
`default_nettype wire

@@ sv/mvm_back.sv @@
`default_nettype none
module mvm_back #(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 16
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         q_empty,
    input  wire mvm_pkg::q_entry_t            q_data,
    output logic                              q_pop,
    input  wire mvm_pkg::cfg_t                cfg,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [mvm_pkg::IDX_W-1:0]         m_row,
    output logic [mvm_pkg::DATA_W-1:0]        m_dot,
    output logic                              m_last
);
    import mvm_pkg::*;

    localparam int ROW_LIM   = (MAX_ROWS < IDX_LIM) ? MAX_ROWS : IDX_LIM;
    localparam int COL_LIM   = (MAX_COLS < IDX_LIM) ? MAX_COLS : IDX_LIM;
    localparam int MAT_DEPTH = ROW_LIM * COL_LIM;
    localparam int MA_W      = (MAT_DEPTH > 1) ? $clog2(MAT_DEPTH) : 1;
    localparam int VA_W      = (COL_LIM > 1) ? $clog2(COL_LIM) : 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic [DATA_W-1:0]        mat_mem [MAT_DEPTH];
    logic [DATA_W-1:0]        vec_mem [COL_LIM];

    logic                     state_reg, state_next;
    logic [IDX_W-1:0]         row_reg, row_next;
    logic [IDX_W-1:0]         col_reg, col_next;

    logic                     adv;
    logic                     rd_en;
    logic                     mat_we;
    logic                     vec_we;
    logic [MA_W-1:0]          wr_addr;
    logic [MA_W-1:0]          rd_addr;
    tag_t                     rd_tag;

    logic signed [DATA_W-1:0] a_reg;
    logic signed [DATA_W-1:0] b_reg;
    logic                     s1_valid_reg;
    tag_t                     s1_tag_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     s2_valid_reg;
    tag_t                     s2_tag_reg;
    logic [ACC_W-1:0]         acc_reg;
    logic [ACC_W-1:0]         prod_ext;
    logic                     s3_valid_reg;
    tag_t                     s3_tag_reg;
    logic [ACC_W-1:0]         rnd_sum;
    logic [DATA_W-1:0]        sat_val;
    logic                     fits;

    logic                     m_valid_reg;
    logic [IDX_W-1:0]         m_row_reg;
    logic [DATA_W-1:0]        m_dot_reg;
    logic                     m_last_reg;

    // Freeze the whole back end while a result waits to be taken.
    assign adv = !m_valid_reg || m_ready;

    assign q_pop   = (state_reg == ST_IDLE) && !q_empty && adv;
    assign mat_we  = q_pop && (q_data.kind == KIND_MAT);
    assign vec_we  = q_pop && (q_data.kind == KIND_VEC);
    assign wr_addr = MA_W'(int'(q_data.row) * COL_LIM + int'(q_data.col));
    assign rd_en   = (state_reg == ST_RUN) && adv;
    assign rd_addr = MA_W'(int'(row_reg) * COL_LIM + int'(col_reg));

    assign rd_tag.first    = (col_reg == '0);
    assign rd_tag.last_col = (col_reg == cfg.cols_last);
    assign rd_tag.last_row = (row_reg == cfg.rows_last);
    assign rd_tag.row      = row_reg;

    always_comb begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_pop && (q_data.kind == KIND_CMP)) begin
                    state_next = ST_RUN;
                    row_next   = '0;
                    col_next   = '0;
                end
            end
            ST_RUN: begin
                if (adv) begin
                    if (rd_tag.last_col) begin
                        col_next = '0;
                        row_next = row_reg + 1'b1;
                        if (rd_tag.last_row) state_next = ST_IDLE;
                    end else begin
                        col_next = col_reg + 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            row_reg      <= '0;
            col_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            if (adv) begin
                s1_valid_reg <= rd_en;
                s2_valid_reg <= s1_valid_reg;
                s3_valid_reg <= s2_valid_reg && s2_tag_reg.last_col;
                m_valid_reg  <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mat_we) mat_mem[wr_addr] <= q_data.data;
        if (rd_en)  a_reg <= mat_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (vec_we) vec_mem[q_data.col[VA_W-1:0]] <= q_data.data;
        if (rd_en)  b_reg <= vec_mem[col_reg[VA_W-1:0]];
    end

    assign prod_ext = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    // Round half up at bit 15, then clip to the signed 32-bit range.
    assign rnd_sum = acc_reg + RND_BIAS;
    assign fits    = (&rnd_sum[ACC_W-1:DATA_W+15]) || !(|rnd_sum[ACC_W-1:DATA_W+15]);
    assign sat_val = fits ? rnd_sum[DATA_W+15:16]
                   : (rnd_sum[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                       : {1'b0, {(DATA_W-1){1'b1}}});

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_tag_reg <= rd_tag;
            s2_tag_reg <= s1_tag_reg;
            prod_reg   <= a_reg * b_reg;
            s3_tag_reg <= s2_tag_reg;
            if (s2_valid_reg) begin
                acc_reg <= s2_tag_reg.first ? prod_ext : acc_reg + prod_ext;
            end
            if (s3_valid_reg) begin
                m_row_reg  <= s3_tag_reg.row;
                m_dot_reg  <= sat_val;
                m_last_reg <= s3_tag_reg.last_row;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_row   = m_row_reg;
    assign m_dot   = m_dot_reg;
    assign m_last  = m_last_reg;

endmodule
`default_nettype wire

@@ sv/mvm_checker.sv @@
`default_nettype none
`include "matrix_vector_multiply_top_assert.svh"
module mvm_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         m_tvalid,
    input wire logic                         m_tready,
    input wire logic [mvm_pkg::TDATA_W-1:0]  m_tdata,
    input wire logic                         m_tlast
);
    import mvm_pkg::*;

    logic [IDX_W-1:0] exp_row_reg;

    // Track the row the next result must carry.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_row_reg <= '0;
        end else if (m_tvalid && m_tready) begin
            exp_row_reg <= m_tlast ? '0 : m_tdata[IDX_W-1:0] + 1'b1;
        end
    end

    `MVM_ASSERT_NXT_ALWAYS(a_reset_clears_out, aclk, !aresetn, !m_tvalid)
    `MVM_ASSERT_NXT(a_out_holds, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    `MVM_ASSERT_IMP(a_row_order, aclk, aresetn, m_tvalid, m_tdata[IDX_W-1:0] == exp_row_reg)
    `MVM_ASSERT_IMP(a_top_row_last, aclk, aresetn, m_tvalid && (m_tdata[IDX_W-1:0] == 4'hF), m_tlast)

endmodule

bind matrix_vector_multiply_top mvm_checker u_mvm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
`default_nettype wire
